// ----- design/week_seconds_to_calendar_assert.svh -----
// Assertion macros for the week-seconds to calendar converter.
// Depends on nothing; include in modules that carry concurrent checks.
`ifndef WEEK_SECONDS_TO_CALENDAR_ASSERT_SVH
`define WEEK_SECONDS_TO_CALENDAR_ASSERT_SVH

`ifndef ASSERT_OFF
`define W2C_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("w2c check failed");
`define W2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("w2c sequence check failed");
`else
`define W2C_ASSERT(lbl, clk, rst_n, prop)
`define W2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/wks2cal_pkg.sv -----
// Constants and tables for the week-seconds to calendar converter.
// No dependencies; imported by week_seconds_to_calendar.
`default_nettype none

package wks2cal_pkg;

	localparam int unsigned IN_W   = 48;
	localparam int unsigned OUT_W  = 48;
	localparam int unsigned NST    = 14;

	// minute split: (ms >> 5) / 1875 by reciprocal
	localparam logic [14:0] MIN_RECIP  = 15'd17895;
	localparam logic [10:0] MIN_DIV    = 11'd1875;
	// hour split: (minutes >> 2) / 15 by reciprocal
	localparam logic [9:0]  HOUR_RECIP = 10'd546;
	localparam logic [3:0]  HOUR_DIV   = 4'd15;
	// century term: (100c - 12210) / 36525 by reciprocal
	localparam logic [12:0] CENT_RECIP = 13'd7349;
	localparam logic [16:0] CENT_DIV   = 17'd36525;

	localparam logic [21:0] JD_EPOCH   = 22'd2445782;
	localparam logic [27:0] Y_OFFSET   = 28'd244565990;
	localparam logic [12:0] YEAR_BASE  = 13'd4715;
	localparam logic [3:0]  MARCH      = 4'd3;
	localparam logic [4:0]  F_WRAP     = 5'd14;

	typedef logic [8:0] day_ofs_t;

	// smallest r with floor(10000 r / 306001) >= k
	localparam day_ofs_t F_THRESH [1:15] = '{
		9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
		9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
	};

	// floor(306001 f / 10000)
	localparam day_ofs_t DOM_BASE [0:15] = '{
		9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
	};

endpackage

`default_nettype wire

// ----- design/week_seconds_to_calendar.sv -----
// Top level: week number and time of week to calendar date and time of day.
// Depends on wks2cal_pkg and week_seconds_to_calendar_assert.svh.
//
//  channel   dir  fields (low bit first)
//  s_axis    in   week_number[12:0], week_millis[42:13], zero pad
//  m_axis    out  year, month, day, hour, minute, minute_millis
//
// Fourteen register stages; one transaction enters per cycle unless every stage is full and the output stalls.
// The reciprocal multiply, subtract and correct steps of each of the three constant
// divisions are split over three stages.
// Reset clears only the stage valid bits; data registers carry no reset.
// A stalled output holds; empty stages still fill, so input is taken while
// a result waits.
`default_nettype none

`include "week_seconds_to_calendar_assert.svh"

module week_seconds_to_calendar
	import wks2cal_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // week_number[12:0], week_millis[42:13]
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata   // year[11:0], month[15:12], day[20:16],
	                                             // hour[25:21], minute[31:26],
	                                             // minute_millis[47:32]
);

	logic [NST-1:0] stage_vld_q;
	logic [NST-1:0] adv;

	// stage 1
	logic [24:0] x_s1;
	logic [39:0] prod_s1;
	logic [4:0]  lo5_s1;
	logic [15:0] w7_s1;
	// stage 2
	logic [14:0] q0_s2;
	logic [11:0] rem0_s2;
	logic [4:0]  lo5_s2;
	logic [15:0] w7_s2;
	// stage 3
	logic [14:0] mt_s3;
	logic [15:0] mmil_s3;
	logic [15:0] w7_s3;
	// stage 4
	logic [22:0] hprod_s4;
	logic [14:0] mt_s4;
	logic [15:0] mmil_s4;
	logic [15:0] w7_s4;
	// stage 5
	logic [9:0]  hq0_s5;
	logic [4:0]  hrem_s5;
	logic [1:0]  lo2_s5;
	logic [15:0] mmil_s5;
	logic [15:0] w7_s5;
	// stage 6
	logic [8:0]  ht_s6;
	logic [5:0]  minute_s6;
	logic [15:0] mmil_s6;
	logic [15:0] w7_s6;
	// stage 7
	logic [3:0]  days_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  minute_s7;
	logic [15:0] mmil_s7;
	logic [15:0] w7_s7;
	// stage 8
	logic [21:0] c_s8;
	logic [27:0] y_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  minute_s8;
	logic [15:0] mmil_s8;
	// stage 9
	logic [40:0] dprod_s9;
	logic [27:0] y_s9;
	logic [21:0] c_s9;
	logic [4:0]  hour_s9;
	logic [5:0]  minute_s9;
	logic [15:0] mmil_s9;
	// stage 10
	logic [12:0] dq0_s10;
	logic [16:0] drem_s10;
	logic [21:0] c_s10;
	logic [4:0]  hour_s10;
	logic [5:0]  minute_s10;
	logic [15:0] mmil_s10;
	// stage 11
	logic [12:0] d_s11;
	logic [21:0] c_s11;
	logic [4:0]  hour_s11;
	logic [5:0]  minute_s11;
	logic [15:0] mmil_s11;
	// stage 12
	logic [8:0]  r_s12;
	logic [12:0] d_s12;
	logic [4:0]  hour_s12;
	logic [5:0]  minute_s12;
	logic [15:0] mmil_s12;
	// stage 13
	logic [3:0]  f_s13;
	logic [3:0]  mon_s13;
	logic [8:0]  r_s13;
	logic [12:0] d_s13;
	logic [4:0]  hour_s13;
	logic [5:0]  minute_s13;
	logic [15:0] mmil_s13;
	// stage 14
	logic [11:0] year_s14;
	logic [3:0]  month_s14;
	logic [4:0]  day_s14;
	logic [4:0]  hour_s14;
	logic [5:0]  minute_s14;
	logic [15:0] mmil_s14;

	// combinational next values
	logic [14:0] q0_n;
	logic [24:0] rem_full_n;
	logic [14:0] mt_n;
	logic [10:0] mrem_n;
	logic [9:0]  hq0_n;
	logic [12:0] hrem_full_n;
	logic [8:0]  ht_n;
	logic [3:0]  mmin_n;
	logic [3:0]  days_n;
	logic [8:0]  hour_full_n;
	logic [15:0] dsum_n;
	logic [12:0] dq0_n;
	logic [27:0] drem_full_n;
	logic [12:0] d_n;
	logic [21:0] e_n;
	logic [21:0] r_full_n;
	logic [3:0]  f_n;
	logic [3:0]  mon_n;
	logic [8:0]  dom_full_n;
	logic [12:0] yr_full_n;

	always_comb begin
		adv[NST-1] = !stage_vld_q[NST-1] | m_axis_tready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !stage_vld_q[i] | adv[i+1];
		end
	end

	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = stage_vld_q[NST-1];
	assign m_axis_tdata  = {mmil_s14, minute_s14, hour_s14, day_s14, month_s14, year_s14};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[0]) begin
				stage_vld_q[0] <= s_axis_tvalid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	always_comb begin
		q0_n       = prod_s1[39:25];
		rem_full_n = x_s1 - 25'(q0_n) * 25'(MIN_DIV);

		if (rem0_s2 >= 12'(MIN_DIV)) begin
			mt_n   = q0_s2 + 15'd1;
			mrem_n = 11'(rem0_s2 - 12'(MIN_DIV));
		end else begin
			mt_n   = q0_s2;
			mrem_n = rem0_s2[10:0];
		end

		hq0_n       = hprod_s4[22:13];
		hrem_full_n = mt_s4[14:2] - 13'(hq0_n) * 13'(HOUR_DIV);

		if (hrem_s5 >= 5'(HOUR_DIV)) begin
			ht_n   = 9'(hq0_s5) + 9'd1;
			mmin_n = 4'(hrem_s5 - 5'(HOUR_DIV));
		end else begin
			ht_n   = 9'(hq0_s5);
			mmin_n = hrem_s5[3:0];
		end

		days_n = '0;
		for (int k = 1; k <= 12; k++) begin
			days_n = days_n + 4'(ht_s6 >= 9'(24 * k));
		end
		hour_full_n = ht_s6 - 9'(days_n) * 9'd24;

		dsum_n = w7_s7 + 16'(days_s7);

		dq0_n       = dprod_s9[40:28];
		drem_full_n = y_s9 - 28'(dq0_n) * 28'(CENT_DIV);

		d_n = (drem_s10 >= CENT_DIV) ? dq0_s10 + 13'd1 : dq0_s10;

		e_n      = 22'(d_s11) * 22'd365 + 22'(d_s11[12:2]);
		r_full_n = c_s11 - e_n;

		f_n = '0;
		for (int k = 1; k <= 15; k++) begin
			f_n = f_n + 4'(r_s12 >= F_THRESH[k]);
		end
		mon_n = (5'(f_n) >= F_WRAP) ? f_n - 4'd13 : f_n - 4'd1;

		dom_full_n = r_s13 - DOM_BASE[f_s13];
		yr_full_n  = d_s13 - YEAR_BASE - 13'(mon_s13 >= MARCH);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_s1    <= s_axis_tdata[42:18];
			prod_s1 <= 40'(s_axis_tdata[42:18]) * 40'(MIN_RECIP);
			lo5_s1  <= s_axis_tdata[17:13];
			w7_s1   <= 16'(s_axis_tdata[12:0]) * 16'd7;
		end
		if (adv[1]) begin
			q0_s2   <= q0_n;
			rem0_s2 <= rem_full_n[11:0];
			lo5_s2  <= lo5_s1;
			w7_s2   <= w7_s1;
		end
		if (adv[2]) begin
			mt_s3   <= mt_n;
			mmil_s3 <= {mrem_n, lo5_s2};
			w7_s3   <= w7_s2;
		end
		if (adv[3]) begin
			hprod_s4 <= 23'(mt_s3[14:2]) * 23'(HOUR_RECIP);
			mt_s4    <= mt_s3;
			mmil_s4  <= mmil_s3;
			w7_s4    <= w7_s3;
		end
		if (adv[4]) begin
			hq0_s5  <= hq0_n;
			hrem_s5 <= hrem_full_n[4:0];
			lo2_s5  <= mt_s4[1:0];
			mmil_s5 <= mmil_s4;
			w7_s5   <= w7_s4;
		end
		if (adv[5]) begin
			ht_s6     <= ht_n;
			minute_s6 <= {mmin_n, lo2_s5};
			mmil_s6   <= mmil_s5;
			w7_s6     <= w7_s5;
		end
		if (adv[6]) begin
			days_s7   <= days_n;
			hour_s7   <= hour_full_n[4:0];
			minute_s7 <= minute_s6;
			mmil_s7   <= mmil_s6;
			w7_s7     <= w7_s6;
		end
		if (adv[7]) begin
			c_s8      <= 22'(dsum_n) + JD_EPOCH;
			y_s8      <= 28'(dsum_n) * 28'd100 + Y_OFFSET;
			hour_s8   <= hour_s7;
			minute_s8 <= minute_s7;
			mmil_s8   <= mmil_s7;
		end
		if (adv[8]) begin
			dprod_s9  <= 41'(y_s8) * 41'(CENT_RECIP);
			y_s9      <= y_s8;
			c_s9      <= c_s8;
			hour_s9   <= hour_s8;
			minute_s9 <= minute_s8;
			mmil_s9   <= mmil_s8;
		end
		if (adv[9]) begin
			dq0_s10    <= dq0_n;
			drem_s10   <= drem_full_n[16:0];
			c_s10      <= c_s9;
			hour_s10   <= hour_s9;
			minute_s10 <= minute_s9;
			mmil_s10   <= mmil_s9;
		end
		if (adv[10]) begin
			d_s11      <= d_n;
			c_s11      <= c_s10;
			hour_s11   <= hour_s10;
			minute_s11 <= minute_s10;
			mmil_s11   <= mmil_s10;
		end
		if (adv[11]) begin
			r_s12      <= r_full_n[8:0];
			d_s12      <= d_s11;
			hour_s12   <= hour_s11;
			minute_s12 <= minute_s11;
			mmil_s12   <= mmil_s11;
		end
		if (adv[12]) begin
			f_s13      <= f_n;
			mon_s13    <= mon_n;
			r_s13      <= r_s12;
			d_s13      <= d_s12;
			hour_s13   <= hour_s12;
			minute_s13 <= minute_s12;
			mmil_s13   <= mmil_s12;
		end
		if (adv[13]) begin
			year_s14   <= yr_full_n[11:0];
			month_s14  <= mon_s13;
			day_s14    <= dom_full_n[4:0];
			hour_s14   <= hour_s13;
			minute_s14 <= minute_s13;
			mmil_s14   <= mmil_s13;
		end
	end

	`W2C_ASSERT(a_mmil_range, clk, arst_n, stage_vld_q[2] |-> mmil_s3 < 16'd60000)
	`W2C_ASSERT(a_minute_range, clk, arst_n, stage_vld_q[5] |-> minute_s6 < 6'd60)
	`W2C_ASSERT(a_month_range, clk, arst_n, stage_vld_q[12] |-> (mon_s13 != 4'd0 && mon_s13 <= 4'd12))
	`W2C_ASSERT(a_full_on_stall, clk, arst_n, !s_axis_tready |-> ((&stage_vld_q) && !m_axis_tready))
	`W2C_ASSERT_NEXT(a_fill_bubble, clk, arst_n, s_axis_tvalid && !stage_vld_q[0], stage_vld_q[0])

endmodule

`default_nettype wire

// ----- bench/week_seconds_to_calendar_test.sv -----
// Self-checking bench for week_seconds_to_calendar: directed table, then random timestamps.
// Predicts dates and times of day in integer arithmetic, but typed table rows give theirs.
// Depends on wks2cal_pkg for the stream widths and on the converter RTL.
`timescale 1ns / 1ps

module week_seconds_to_calendar_test;
	import wks2cal_pkg::IN_W;
	import wks2cal_pkg::OUT_W;

	localparam longint unsigned DAY_MS    = 64'd86400000;
	localparam longint unsigned HOUR_MS   = 64'd3600000;
	localparam longint unsigned MINUTE_MS = 64'd60000;
	localparam longint unsigned EPOCH_JDN = 64'd2445782;
	localparam int unsigned     WEEK_MS   = 604800000;
	localparam int unsigned     RANDOM_STAMPS = 1500;
	localparam int unsigned     LONG_HOLD     = 200;
	localparam int unsigned     SETTLE_CYCLES = 40;
	localparam int unsigned     CYCLE_LIMIT   = 500000;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] minute_millis;
	} calendar_t;

	typedef struct packed {
		logic [12:0] wk;
		logic [29:0] ms;
		bit          typed;
		calendar_t   want;
	} stamp_row_t;

	typedef enum {PACE_FREE, PACE_HALF, PACE_MOSTLY, PACE_SPARSE} pace_t;

	localparam int unsigned DIRECTED_COUNT = 19;
	localparam stamp_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{13'd0,    30'd0,          1'b1, '{12'd1980, 4'd1, 5'd6,  5'd0,  6'd0,  16'd0}},
		'{13'd0,    30'd59999,      1'b1, '{12'd1980, 4'd1, 5'd6,  5'd0,  6'd0,  16'd59999}},
		'{13'd0,    30'd60000,      1'b1, '{12'd1980, 4'd1, 5'd6,  5'd0,  6'd1,  16'd0}},
		'{13'd0,    30'd3599999,    1'b1, '{12'd1980, 4'd1, 5'd6,  5'd0,  6'd59, 16'd59999}},
		'{13'd0,    30'd3600000,    1'b1, '{12'd1980, 4'd1, 5'd6,  5'd1,  6'd0,  16'd0}},
		'{13'd0,    30'd86399999,   1'b1, '{12'd1980, 4'd1, 5'd6,  5'd23, 6'd59, 16'd59999}},
		'{13'd0,    30'd86400000,   1'b1, '{12'd1980, 4'd1, 5'd7,  5'd0,  6'd0,  16'd0}},
		'{13'd0,    30'd604799999,  1'b1, '{12'd1980, 4'd1, 5'd12, 5'd23, 6'd59, 16'd59999}},
		'{13'd1,    30'd0,          1'b1, '{12'd1980, 4'd1, 5'd13, 5'd0,  6'd0,  16'd0}},
		'{13'd0,    30'h3FFFFFFF,   1'b1, '{12'd1980, 4'd1, 5'd18, 5'd10, 6'd15, 16'd41823}},
		'{13'd7,    30'd432000000,  1'b0, '0},
		'{13'd1024, 30'd0,          1'b0, '0},
		'{13'd2048, 30'd0,          1'b0, '0},
		'{13'd8191, 30'd0,          1'b0, '0},
		'{13'd8191, 30'd604799999,  1'b0, '0},
		'{13'd8191, 30'h3FFFFFFF,   1'b0, '0},
		'{13'h1555, 30'h2AAAAAAA,   1'b0, '0},
		'{13'h0AAA, 30'h15555555,   1'b0, '0},
		'{13'd4096, 30'd604800000,  1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;   // week_number[12:0], week_millis[42:13], zero pad
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // year, month, day, hour, minute, minute_millis

	calendar_t   pending_dates [$];
	int unsigned mismatches = 0;
	int unsigned stamps_sent = 0;
	int unsigned dates_checked = 0;
	int unsigned beyond_week = 0;
	int unsigned cycles = 0;
	bit          hold_asked = 1'b0;
	bit          hold_served = 1'b0;
	bit          draining = 1'b0;

	week_seconds_to_calendar dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic calendar_t convert_stamp(input logic [12:0] wk, input logic [29:0] ms);
		longint unsigned wk64, ms64, jdn, cent, cent_days, rem_days, mon_idx, mon_val, yr_val;
		calendar_t res;
		wk64 = wk;
		ms64 = ms;
		jdn = 64'd7 * wk64 + ms64 / DAY_MS + EPOCH_JDN;
		cent = (64'd100 * jdn - 64'd12210) / 64'd36525;
		cent_days = 64'd365 * cent + cent / 64'd4;
		rem_days = jdn - cent_days;
		mon_idx = (64'd10000 * rem_days) / 64'd306001;
		mon_val = mon_idx - 64'd1 - 64'd12 * (mon_idx / 64'd14);
		yr_val = cent - 64'd4715 - (64'd7 + mon_val) / 64'd10;
		res.year = 12'(yr_val);
		res.month = 4'(mon_val);
		res.day = 5'(rem_days - (64'd306001 * mon_idx) / 64'd10000);
		res.hour = 5'((ms64 / HOUR_MS) % 64'd24);
		res.minute = 6'((ms64 / MINUTE_MS) % 64'd60);
		res.minute_millis = 16'(ms64 % MINUTE_MS);
		return res;
	endfunction

	function automatic void pick_stamp(output logic [12:0] wk, output logic [29:0] ms);
		int unsigned kind, edge_kind, base;
		kind = $urandom_range(0, 9);
		wk = 13'($urandom_range(0, 8191));
		if (kind < 6) begin
			ms = 30'($urandom_range(0, WEEK_MS - 1));
		end else if (kind < 8) begin
			edge_kind = $urandom_range(0, 2);
			base = $urandom_range(0, 6) * 86400000 + $urandom_range(0, 23) * 3600000
				+ $urandom_range(0, 59) * 60000;
			case (edge_kind)
				0: ms = 30'(base);
				1: ms = 30'(base + 59999);
				default: ms = 30'(base + $urandom_range(0, 59999));
			endcase
		end else if (kind == 8) begin
			ms = 30'($urandom_range(WEEK_MS, 32'h3FFFFFFF));
		end else begin
			wk = $urandom_range(0, 1) ? 13'h1FFF : 13'h0000;
			ms = 30'($urandom_range(0, 32'h3FFFFFFF));
		end
	endfunction

	task automatic offer_stamp(input logic [12:0] wk, input logic [29:0] ms, input bit typed,
			input calendar_t want);
		bit took;
		took = 1'b0;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, ms, wk};
		while (!took) begin
			@(negedge clk);
			took = s_axis_tready;
			if (took)
				pending_dates.push_back(typed ? want : convert_stamp(wk, ms));
			@(posedge clk);
		end
		stamps_sent++;
		if (ms >= WEEK_MS)
			beyond_week++;
	endtask

	task automatic idle_sender(input int unsigned n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_for_dates;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	// check every result transaction against the oldest pending date
	initial begin : date_checker
		calendar_t got, want;
		forever begin
			@(negedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.year = m_axis_tdata[11:0];
				got.month = m_axis_tdata[15:12];
				got.day = m_axis_tdata[20:16];
				got.hour = m_axis_tdata[25:21];
				got.minute = m_axis_tdata[31:26];
				got.minute_millis = m_axis_tdata[47:32];
				if (pending_dates.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result %0d-%0d-%0d %0d:%0d +%0d ms", $time,
						got.year, got.month, got.day, got.hour, got.minute, got.minute_millis);
				end else begin
					want = pending_dates.pop_front();
					dates_checked++;
					if (got.year !== want.year || got.month !== want.month
							|| got.day !== want.day || got.hour !== want.hour
							|| got.minute !== want.minute
							|| got.minute_millis !== want.minute_millis) begin
						mismatches++;
						$display("%0t: expected %0d-%0d-%0d %0d:%0d +%0d ms, got %0d-%0d-%0d %0d:%0d +%0d ms",
							$time, want.year, want.month, want.day, want.hour, want.minute,
							want.minute_millis, got.year, got.month, got.day, got.hour,
							got.minute, got.minute_millis);
					end
				end
			end
		end
	end

	// pace the result side; serve one long hold when asked
	initial begin : sink_pacing
		pace_t mode;
		int unsigned left;
		mode = PACE_FREE;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asked && !hold_served) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				hold_served = 1'b1;
			end else if (draining) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (left == 0) begin
					mode = pace_t'($urandom_range(0, 3));
					left = $urandom_range(32, 256);
				end
				left--;
				case (mode)
					PACE_FREE:   m_axis_tready <= 1'b1;
					PACE_HALF:   m_axis_tready <= ($urandom_range(0, 99) < 50);
					PACE_MOSTLY: m_axis_tready <= ($urandom_range(0, 99) < 75);
					PACE_SPARSE: m_axis_tready <= ($urandom_range(0, 99) < 20);
				endcase
			end
		end
	end

	initial begin : cycle_watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timed out with %0d dates pending", $time, pending_dates.size());
		$display("week_seconds_to_calendar_test: errors");
		$finish;
	end

	initial begin : stamp_source
		logic [12:0] wk;
		logic [29:0] ms;
		int unsigned sent, burst, gap;
		bit paused_once;
		sent = 0;
		paused_once = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			offer_stamp(DIRECTED_ROWS[i].wk, DIRECTED_ROWS[i].ms, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].want);
			if ($urandom_range(0, 2) == 0)
				idle_sender($urandom_range(1, 5));
		end

		while (sent < RANDOM_STAMPS) begin
			burst = $urandom_range(1, 40);
			if (!hold_asked && sent >= 700) begin
				hold_asked = 1'b1;
				burst = 150;
			end
			repeat (burst) begin
				pick_stamp(wk, ms);
				offer_stamp(wk, ms, 1'b0, '0);
				sent++;
			end
			if (!paused_once && sent >= 350) begin
				wait_for_dates();
				paused_once = 1'b1;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0)
				idle_sender(gap);
		end

		draining = 1'b1;
		wait_for_dates();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d timestamps (%0d from the table, %0d beyond one week)",
			stamps_sent, DIRECTED_COUNT, beyond_week);
		$display("checked %0d dates in %0d cycles, one long output hold served", dates_checked,
			cycles);
		if (mismatches == 0)
			$display("week_seconds_to_calendar_test: clean");
		else
			$display("week_seconds_to_calendar_test: errors");
		$finish;
	end

endmodule

// ----- week_seconds_to_calendar.f -----
+incdir+design
design/wks2cal_pkg.sv
design/week_seconds_to_calendar.sv
bench/week_seconds_to_calendar_test.sv
